[sv/smcn_pkg.sv]
// ----------------------------------------------------------------------------
// smcn_pkg
// Shared types and constants of the sensor min/max calibrate normalize core.
// ----------------------------------------------------------------------------
package smcn_pkg;

   localparam int CHANNELS = 8;
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [2:0] OP_NORMALIZE = 3'd0;
   localparam logic [2:0] OP_START_CAL = 3'd1;
   localparam logic [2:0] OP_CAL_SAMPLE = 3'd2;
   localparam logic [2:0] OP_LOAD_ENTRY = 3'd3;
   localparam logic [2:0] OP_TAKE_DONE = 3'd4;
   localparam logic [2:0] OP_DEFAULTS = 3'd5;
   localparam logic [2:0] OP_READ_ENTRY = 3'd6;

   localparam logic [2:0] REG_VALID_SPAN = 3'd0;
   localparam logic [2:0] REG_OUT_SCALE = 3'd1;
   localparam logic [2:0] REG_ADC_FULL = 3'd2;
   localparam logic [2:0] REG_PERIOD_MS = 3'd3;
   localparam logic [2:0] REG_CALIB_TIME = 3'd4;
   localparam logic [2:0] REG_GAIN = 3'd5;

   // Multiplying by this and shifting right by 33 divides any value below
   // 2**26 by 100 exactly.
   localparam logic [26:0] RECIP_100 = 27'd85899346;

   typedef struct packed {
      logic [2:0] operation;
      logic [3:0] channel;
      logic [15:0] raw_sample;
      logic last_of_group;
      logic [15:0] new_low;
      logic [15:0] new_high;
   } req_type;

   typedef struct packed {
      logic [15:0] norm_value;
      logic [15:0] entry_low;
      logic [15:0] entry_high;
      logic calibrating;
      logic done_flag;
      logic [6:0] progress_percent;
   } rsp_type;

   typedef struct packed {
      logic [15:0] valid_span;
      logic [15:0] out_scale;
      logic [15:0] adc_full;
      logic [7:0] period_ms;
      logic [15:0] cal_time_ms;
      logic [9:0] gain_percent;
   } cfg_type;

endpackage

[sv/smcn_front.sv]
// ----------------------------------------------------------------------------
// smcn_front
// Accepts items and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module smcn_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  smcn_pkg::req_type req_data,
   output logic q_valid,
   input  logic q_take,
   output smcn_pkg::req_type q_data
);

   smcn_pkg::req_type buf_ff [2];
   smcn_pkg::req_type buf_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic push;

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = buf_ff[0];

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (q_take && q_valid) begin
         buf_in[0] = buf_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (push) begin
         buf_in[cnt_in[0]] = req_data;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   a_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !q_take) |=> cnt_ff == 2'd2)
      else $error("queue lost an item");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 && !req_valid) |=> cnt_ff == 2'd0)
      else $error("queue invented an item");

endmodule

[sv/smcn_back.sv]
// ----------------------------------------------------------------------------
// smcn_back
// Executes one item at a time: table updates, serial division, finish walk.
// ----------------------------------------------------------------------------
module smcn_back (
   input  logic clock,
   input  logic reset,
   input  smcn_pkg::cfg_type cfg,
   input  logic q_valid,
   output logic q_take,
   input  smcn_pkg::req_type q_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output smcn_pkg::rsp_type rsp_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV = 3'd1;
   localparam logic [2:0] ST_FIN = 3'd2;
   localparam logic [2:0] ST_PROG = 3'd3;
   localparam logic [2:0] ST_OUT = 3'd4;
   localparam logic [2:0] ST_MUL = 3'd5;

   logic [2:0] st_ff, st_in;
   logic [15:0] low_ff [smcn_pkg::CHANNELS];
   logic [15:0] low_in [smcn_pkg::CHANNELS];
   logic [15:0] high_ff [smcn_pkg::CHANNELS];
   logic [15:0] high_in [smcn_pkg::CHANNELS];
   logic [15:0] tmin_ff [smcn_pkg::CHANNELS];
   logic [15:0] tmin_in [smcn_pkg::CHANNELS];
   logic [15:0] tmax_ff [smcn_pkg::CHANNELS];
   logic [15:0] tmax_in [smcn_pkg::CHANNELS];
   logic [15:0] elapsed_ff, elapsed_in;
   logic busy_ff, busy_in, fin_ff, fin_in;
   logic [31:0] num_ff, num_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] den_ff, den_in;
   logic [5:0] bit_ff, bit_in;
   logic [1:0] kind_ff, kind_in;
   logic [smcn_pkg::CH_W-1:0] walk_ff, walk_in;
   smcn_pkg::rsp_type out_ff, out_in;
   smcn_pkg::rsp_type res_ff, res_in;
   logic ov_ff, ov_in;
   logic [16:0] sum;
   logic [16:0] trial;
   logic [31:0] prod;
   logic [52:0] recip;
   logic [19:0] quo;
   logic [smcn_pkg::CH_W-1:0] chi;
   logic ch_ok;
   logic [15:0] lo, hi, span;

   localparam logic [1:0] K_NORM = 2'd0;
   localparam logic [1:0] K_PROG = 2'd2;

   assign chi = q_data.channel[smcn_pkg::CH_W-1:0];
   assign ch_ok = ({1'b0, q_data.channel} < 5'(smcn_pkg::CHANNELS));
   assign lo = low_ff[chi];
   assign hi = high_ff[chi];
   assign span = hi - lo;
   assign trial = {rem_ff[15:0], num_ff[31]};
   assign prod = 32'(tmax_ff[walk_ff]) * 32'(cfg.gain_percent);
   assign recip = 53'(num_ff[25:0]) * 53'(smcn_pkg::RECIP_100);
   assign quo = recip[52:33];
   assign sum = 17'(elapsed_ff) + 17'(cfg.period_ms);
   assign q_take = (st_ff == ST_OUT) && (!ov_ff || !rsp_stall);
   assign rsp_valid = ov_ff;
   assign rsp_data = res_ff;

   always_comb begin
      st_in = st_ff;
      low_in = low_ff;
      high_in = high_ff;
      tmin_in = tmin_ff;
      tmax_in = tmax_ff;
      elapsed_in = elapsed_ff;
      busy_in = busy_ff;
      fin_in = fin_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      bit_in = bit_ff;
      kind_in = kind_ff;
      walk_in = walk_ff;
      out_in = out_ff;
      res_in = res_ff;
      ov_in = ov_ff && rsp_stall;
      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               out_in = '0;
               st_in = ST_PROG;
               case (q_data.operation)
                  smcn_pkg::OP_NORMALIZE: begin
                     if (ch_ok && hi > lo && span >= cfg.valid_span
                         && q_data.raw_sample > lo) begin
                        if (q_data.raw_sample >= hi) begin
                           out_in.norm_value = cfg.out_scale;
                        end else begin
                           num_in = (q_data.raw_sample - lo) * 32'(cfg.out_scale);
                           den_in = span;
                           rem_in = '0;
                           bit_in = 6'd32;
                           kind_in = K_NORM;
                           st_in = ST_DIV;
                        end
                     end
                  end
                  smcn_pkg::OP_START_CAL: begin
                     for (int k = 0; k < smcn_pkg::CHANNELS; k++) begin
                        tmin_in[k] = 16'hFFFF;
                        tmax_in[k] = '0;
                     end
                     elapsed_in = '0;
                     busy_in = 1'b1;
                     fin_in = 1'b0;
                  end
                  smcn_pkg::OP_CAL_SAMPLE: begin
                     if (busy_ff) begin
                        if (ch_ok) begin
                           if (q_data.raw_sample < tmin_ff[chi])
                              tmin_in[chi] = q_data.raw_sample;
                           if (q_data.raw_sample > tmax_ff[chi])
                              tmax_in[chi] = q_data.raw_sample;
                        end
                        if (q_data.last_of_group) begin
                           elapsed_in = sum[16] ? 16'hFFFF : sum[15:0];
                           if (elapsed_in >= cfg.cal_time_ms) begin
                              walk_in = '0;
                              st_in = ST_MUL;
                           end
                        end
                     end
                  end
                  smcn_pkg::OP_LOAD_ENTRY: begin
                     if (ch_ok) begin
                        low_in[chi] = q_data.new_low;
                        high_in[chi] = q_data.new_high;
                     end
                  end
                  smcn_pkg::OP_DEFAULTS: begin
                     for (int k = 0; k < smcn_pkg::CHANNELS; k++) begin
                        low_in[k] = '0;
                        high_in[k] = cfg.adc_full;
                     end
                  end
                  smcn_pkg::OP_READ_ENTRY: begin
                     if (ch_ok) begin
                        out_in.entry_low = lo;
                        out_in.entry_high = hi;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL: begin
            num_in = prod;
            st_in = ST_FIN;
         end
         ST_DIV: begin
            num_in = {num_ff[30:0], 1'b0};
            if (trial >= {1'b0, den_ff}) begin
               rem_in = trial - {1'b0, den_ff};
               num_in[0] = 1'b1;
            end else begin
               rem_in = trial;
            end
            bit_in = bit_ff - 6'd1;
            if (bit_ff == 6'd1) begin
               unique case (kind_ff)
                  K_NORM: begin
                     out_in.norm_value = num_in[15:0];
                     st_in = ST_PROG;
                  end
                  default: begin
                     out_in.progress_percent = (num_in > 32'd100) ? 7'd100 : num_in[6:0];
                     st_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_FIN: begin
            low_in[walk_ff] = (tmin_ff[walk_ff] == 16'hFFFF) ? '0 : tmin_ff[walk_ff];
            high_in[walk_ff] = (quo > 20'(cfg.adc_full)) ? cfg.adc_full : quo[15:0];
            if (32'(walk_ff) == 32'(smcn_pkg::CHANNELS - 1)) begin
               busy_in = 1'b0;
               fin_in = 1'b1;
               st_in = ST_PROG;
            end else begin
               walk_in = walk_ff + 1'b1;
               st_in = ST_MUL;
            end
         end
         ST_PROG: begin
            out_in.calibrating = busy_ff;
            out_in.done_flag = fin_ff;
            if (q_data.operation == smcn_pkg::OP_TAKE_DONE) fin_in = 1'b0;
            if (!busy_ff || cfg.cal_time_ms == '0) begin
               out_in.progress_percent = 7'd100;
               st_in = ST_OUT;
            end else begin
               num_in = 32'(elapsed_ff) * 32'd100;
               den_in = cfg.cal_time_ms;
               rem_in = '0;
               bit_in = 6'd32;
               kind_in = K_PROG;
               st_in = ST_DIV;
            end
         end
         ST_OUT: begin
            if (!ov_ff || !rsp_stall) begin
               ov_in = 1'b1;
               res_in = out_ff;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      bit_ff <= bit_in;
      kind_ff <= kind_in;
      walk_ff <= walk_in;
      out_ff <= out_in;
      res_ff <= res_in;
      if (reset) begin
         st_ff <= ST_IDLE;
         ov_ff <= 1'b0;
         elapsed_ff <= '0;
         busy_ff <= 1'b0;
         fin_ff <= 1'b0;
         for (int k = 0; k < smcn_pkg::CHANNELS; k++) begin
            low_ff[k] <= '0;
            high_ff[k] <= 16'd4095;
            tmin_ff[k] <= 16'hFFFF;
            tmax_ff[k] <= '0;
         end
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
         elapsed_ff <= elapsed_in;
         busy_ff <= busy_in;
         fin_ff <= fin_in;
         low_ff <= low_in;
         high_ff <= high_in;
         tmin_ff <= tmin_in;
         tmax_ff <= tmax_in;
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && rsp_stall) |=> ov_ff && $stable(res_ff))
      else $error("result changed while stalled");
   a_take: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid)
      else $error("took from an empty queue");
   a_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(fin_ff) |-> !busy_ff)
      else $error("finished while busy");

endmodule

[sv/sensor_minmax_calibrate_normalize_core.sv]
// ----------------------------------------------------------------------------
// sensor_minmax_calibrate_normalize_core
// Multichannel min/max calibration and normalization core.
// ----------------------------------------------------------------------------
// Items are queued by a front end and executed one at a time by a back end,
// which sees an item in the cycle after it is accepted. A status-only item then
// passes through the progress and output states to its result; each 32-step
// restoring division lengthens this, so a normalize that divides takes one, and
// a second while a calibration run is in progress, as does the progress of any
// other item during a run. The sample that ends a run walks every channel
// through a multiply and a reciprocal divide by 100.
module sensor_minmax_calibrate_normalize_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  smcn_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output smcn_pkg::rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [15:0] csr_wdata
);

   smcn_pkg::cfg_type cfg_ff, cfg_in;
   logic q_valid, q_take;
   smcn_pkg::req_type q_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            smcn_pkg::REG_VALID_SPAN: cfg_in.valid_span = csr_wdata;
            smcn_pkg::REG_OUT_SCALE: cfg_in.out_scale = csr_wdata;
            smcn_pkg::REG_ADC_FULL: cfg_in.adc_full = csr_wdata;
            smcn_pkg::REG_PERIOD_MS: cfg_in.period_ms = csr_wdata[7:0];
            smcn_pkg::REG_CALIB_TIME: cfg_in.cal_time_ms = csr_wdata;
            smcn_pkg::REG_GAIN: cfg_in.gain_percent = csr_wdata[9:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{valid_span: 16'd100, out_scale: 16'd1000, adc_full: 16'd4095,
                     period_ms: 8'd5, cal_time_ms: 16'd3000, gain_percent: 10'd110};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   smcn_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
   );

   smcn_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_valid(q_valid), .q_take(q_take), .q_data(q_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sensor min/max calibrate normalize core. A
// driver and a monitor exchange items with the core under random idling and
// stalling, while an in-bench model of the calibration table predicts every
// result. Several register settings are run, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   smcn_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   smcn_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = smcn_pkg::REG_VALID_SPAN;
   logic [15:0] csr_wdata = '0;

   sensor_minmax_calibrate_normalize_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the core's calibration state and registers.
   logic [15:0] span_min, full_scale, adc_top, step_ms, run_ms;
   logic [9:0] gain_pct;
   logic [15:0] low_tab [0:smcn_pkg::CHANNELS-1];
   logic [15:0] high_tab [0:smcn_pkg::CHANNELS-1];
   logic [15:0] seen_min [0:smcn_pkg::CHANNELS-1];
   logic [15:0] seen_max [0:smcn_pkg::CHANNELS-1];
   logic [15:0] run_elapsed;
   logic run_busy, run_done;

   smcn_pkg::req_type pending_items [$];
   smcn_pkg::rsp_type expected_rsps [$];
   int send_idle_pct = 0;
   int stall_pct = 0;
   logic hold_request = 1'b0;
   logic hold_seen = 1'b0;
   int hold_left = 0;
   logic failed = 1'b0;

   function automatic logic [15:0] scaled_reading(logic [3:0] ch, logic [15:0] raw);
      logic [31:0] lo, hi;
      if (ch >= smcn_pkg::CHANNELS) return 16'd0;
      lo = 32'(low_tab[ch[smcn_pkg::CH_W-1:0]]);
      hi = 32'(high_tab[ch[smcn_pkg::CH_W-1:0]]);
      if (hi <= lo) return 16'd0;
      if (hi - lo < 32'(span_min)) return 16'd0;
      if (32'(raw) <= lo) return 16'd0;
      if (32'(raw) >= hi) return full_scale;
      return 16'(((32'(raw) - lo) * 32'(full_scale)) / (hi - lo));
   endfunction

   function automatic void close_run();
      logic [31:0] h;
      for (int k = 0; k < smcn_pkg::CHANNELS; k++) begin
         low_tab[k] = (seen_min[k] == 16'hFFFF) ? 16'd0 : seen_min[k];
         h = (32'(seen_max[k]) * 32'(gain_pct)) / 32'd100;
         if (h > 32'(adc_top)) h = 32'(adc_top);
         high_tab[k] = h[15:0];
      end
      run_busy = 1'b0;
      run_done = 1'b1;
   endfunction

   function automatic smcn_pkg::rsp_type calibrate_step(smcn_pkg::req_type it);
      smcn_pkg::rsp_type r;
      logic [31:0] t;
      r = '0;
      case (it.operation)
         smcn_pkg::OP_NORMALIZE: r.norm_value = scaled_reading(it.channel, it.raw_sample);
         smcn_pkg::OP_START_CAL: begin
            for (int k = 0; k < smcn_pkg::CHANNELS; k++) begin
               seen_min[k] = 16'hFFFF;
               seen_max[k] = 16'd0;
            end
            run_elapsed = 16'd0;
            run_busy = 1'b1;
            run_done = 1'b0;
         end
         smcn_pkg::OP_CAL_SAMPLE: if (run_busy) begin
            if (it.channel < smcn_pkg::CHANNELS) begin
               if (it.raw_sample < seen_min[it.channel[smcn_pkg::CH_W-1:0]])
                  seen_min[it.channel[smcn_pkg::CH_W-1:0]] = it.raw_sample;
               if (it.raw_sample > seen_max[it.channel[smcn_pkg::CH_W-1:0]])
                  seen_max[it.channel[smcn_pkg::CH_W-1:0]] = it.raw_sample;
            end
            if (it.last_of_group) begin
               t = 32'(run_elapsed) + 32'(step_ms);
               run_elapsed = (t > 32'hFFFF) ? 16'hFFFF : t[15:0];
               if (run_elapsed >= run_ms) close_run();
            end
         end
         smcn_pkg::OP_LOAD_ENTRY: if (it.channel < smcn_pkg::CHANNELS) begin
            low_tab[it.channel[smcn_pkg::CH_W-1:0]] = it.new_low;
            high_tab[it.channel[smcn_pkg::CH_W-1:0]] = it.new_high;
         end
         smcn_pkg::OP_DEFAULTS: for (int k = 0; k < smcn_pkg::CHANNELS; k++) begin
            low_tab[k] = 16'd0;
            high_tab[k] = adc_top;
         end
         smcn_pkg::OP_READ_ENTRY: if (it.channel < smcn_pkg::CHANNELS) begin
            r.entry_low = low_tab[it.channel[smcn_pkg::CH_W-1:0]];
            r.entry_high = high_tab[it.channel[smcn_pkg::CH_W-1:0]];
         end
         default: ;
      endcase
      r.done_flag = run_done;
      if (it.operation == smcn_pkg::OP_TAKE_DONE) run_done = 1'b0;
      r.calibrating = run_busy;
      if (!run_busy || run_ms == 16'd0) begin
         r.progress_percent = 7'd100;
      end else begin
         t = (32'(run_elapsed) * 32'd100) / 32'(run_ms);
         r.progress_percent = (t > 32'd100) ? 7'd100 : t[6:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_rsps.push_back(calibrate_step(req_data));
         if (!req_valid || !req_stall) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      smcn_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_data);
            failed <= 1'b1;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.norm_value !== want.norm_value ||
                rsp_data.entry_low !== want.entry_low ||
                rsp_data.entry_high !== want.entry_high ||
                rsp_data.calibrating !== want.calibrating ||
                rsp_data.done_flag !== want.done_flag ||
                rsp_data.progress_percent !== want.progress_percent) begin
               $display("%0t: expected %p, actual %p", $time, want, rsp_data);
               failed <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_request && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         smcn_pkg::REG_VALID_SPAN: span_min = val;
         smcn_pkg::REG_OUT_SCALE: full_scale = val;
         smcn_pkg::REG_ADC_FULL: adc_top = val;
         smcn_pkg::REG_PERIOD_MS: step_ms = {8'd0, val[7:0]};
         smcn_pkg::REG_CALIB_TIME: run_ms = val;
         smcn_pkg::REG_GAIN: gain_pct = val[9:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(logic [15:0] vs, logic [15:0] nm, logic [15:0] af,
                           logic [15:0] pm, logic [15:0] ct, logic [15:0] gp);
      write_reg(smcn_pkg::REG_VALID_SPAN, vs);
      write_reg(smcn_pkg::REG_OUT_SCALE, nm);
      write_reg(smcn_pkg::REG_ADC_FULL, af);
      write_reg(smcn_pkg::REG_PERIOD_MS, pm);
      write_reg(smcn_pkg::REG_CALIB_TIME, ct);
      write_reg(smcn_pkg::REG_GAIN, gp);
   endtask

   task automatic add_item(logic [2:0] op, logic [3:0] ch, logic [15:0] raw,
                           logic last, logic [15:0] lo, logic [15:0] hi);
      smcn_pkg::req_type it;
      it.operation = op;
      it.channel = ch;
      it.raw_sample = raw;
      it.last_of_group = last;
      it.new_low = lo;
      it.new_high = hi;
      pending_items.push_back(it);
   endtask

   function automatic logic [3:0] pick_channel();
      if ($urandom_range(0, 99) < 90) return 4'($urandom_range(0, 7));
      return 4'($urandom_range(8, 15));
   endfunction

   task automatic add_random(int count, int last_pct);
      int pick;
      logic [15:0] lo;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         lo = 16'($urandom_range(0, 2000));
         if (pick < 35)
            add_item(smcn_pkg::OP_NORMALIZE, pick_channel(),
                     $urandom_range(0, 1) ? 16'($urandom_range(0, 5000)) : 16'($urandom),
                     1'($urandom), 16'($urandom), 16'($urandom));
         else if (pick < 70)
            add_item(smcn_pkg::OP_CAL_SAMPLE, pick_channel(), 16'($urandom),
                     $urandom_range(0, 99) < last_pct, 16'($urandom), 16'($urandom));
         else if (pick < 73)
            add_item(smcn_pkg::OP_START_CAL, 4'($urandom), 16'($urandom), 1'($urandom),
                     16'($urandom), 16'($urandom));
         else if (pick < 81)
            add_item(smcn_pkg::OP_LOAD_ENTRY, 4'($urandom), 16'($urandom), 1'($urandom),
                     $urandom_range(0, 1) ? lo : 16'($urandom),
                     $urandom_range(0, 1) ? 16'(lo + $urandom_range(0, 3000)) :
                     16'($urandom));
         else if (pick < 89)
            add_item(smcn_pkg::OP_READ_ENTRY, 4'($urandom), 16'($urandom), 1'($urandom),
                     16'($urandom), 16'($urandom));
         else if (pick < 94)
            add_item(smcn_pkg::OP_TAKE_DONE, 4'($urandom), 16'($urandom), 1'($urandom),
                     16'($urandom), 16'($urandom));
         else if (pick < 97)
            add_item(smcn_pkg::OP_DEFAULTS, 4'($urandom), 16'($urandom), 1'($urandom),
                     16'($urandom), 16'($urandom));
         else
            add_item(3'd7, 4'($urandom), 16'($urandom), 1'($urandom),
                     16'($urandom), 16'($urandom));
      end
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_items.size() > 0 || req_valid || expected_rsps.size() > 0);
      repeat (400) @(negedge clock);
   endtask

   initial begin
      span_min = 16'd100;
      full_scale = 16'd1000;
      adc_top = 16'd4095;
      step_ms = 16'd5;
      run_ms = 16'd3000;
      gain_pct = 10'd110;
      for (int k = 0; k < smcn_pkg::CHANNELS; k++) begin
         low_tab[k] = 16'd0;
         high_tab[k] = 16'd4095;
         seen_min[k] = 16'hFFFF;
         seen_max[k] = 16'd0;
      end
      run_elapsed = 16'd0;
      run_busy = 1'b0;
      run_done = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      add_item(smcn_pkg::OP_NORMALIZE, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0);
      add_item(smcn_pkg::OP_NORMALIZE, 4'd0, 16'd2000, 1'b0, 16'd0, 16'd0);
      add_item(smcn_pkg::OP_NORMALIZE, 4'd7, 16'hFFFF, 1'b0, 16'd0, 16'd0);
      add_item(smcn_pkg::OP_NORMALIZE, 4'd15, 16'd2000, 1'b0, 16'd0, 16'd0);
      add_item(smcn_pkg::OP_READ_ENTRY, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0);
      add_item(smcn_pkg::OP_READ_ENTRY, 4'd15, 16'd0, 1'b0, 16'd0, 16'd0);
      add_item(smcn_pkg::OP_LOAD_ENTRY, 4'd3, 16'd0, 1'b0, 16'd1000, 16'd1050);
      add_item(smcn_pkg::OP_NORMALIZE, 4'd3, 16'd1020, 1'b0, 16'd0, 16'd0);
      add_item(smcn_pkg::OP_LOAD_ENTRY, 4'd4, 16'd0, 1'b0, 16'd3000, 16'd3000);
      add_item(smcn_pkg::OP_NORMALIZE, 4'd4, 16'd3000, 1'b0, 16'd0, 16'd0);
      add_item(smcn_pkg::OP_LOAD_ENTRY, 4'd5, 16'd0, 1'b0, 16'd0, 16'hFFFF);
      add_item(smcn_pkg::OP_NORMALIZE, 4'd5, 16'hFFFE, 1'b0, 16'd0, 16'd0);
      add_item(smcn_pkg::OP_LOAD_ENTRY, 4'd15, 16'd0, 1'b0, 16'd5, 16'd9);
      add_item(smcn_pkg::OP_START_CAL, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0);
      add_item(smcn_pkg::OP_CAL_SAMPLE, 4'd1, 16'd500, 1'b0, 16'd0, 16'd0);
      add_item(smcn_pkg::OP_CAL_SAMPLE, 4'd1, 16'hFFFF, 1'b1, 16'd0, 16'd0);
      add_item(smcn_pkg::OP_CAL_SAMPLE, 4'd12, 16'd7, 1'b1, 16'd0, 16'd0);
      add_item(smcn_pkg::OP_LOAD_ENTRY, 4'd2, 16'd0, 1'b0, 16'd10, 16'd20);
      add_item(smcn_pkg::OP_DEFAULTS, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0);
      add_item(smcn_pkg::OP_CAL_SAMPLE, 4'd0, 16'd0, 1'b1, 16'd0, 16'd0);
      add_item(smcn_pkg::OP_CAL_SAMPLE, 4'd2, 16'd100, 1'b1, 16'd0, 16'd0);
      add_item(smcn_pkg::OP_TAKE_DONE, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0);
      add_item(smcn_pkg::OP_TAKE_DONE, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0);
      add_item(smcn_pkg::OP_READ_ENTRY, 4'd1, 16'd0, 1'b0, 16'd0, 16'd0);
      add_item(3'd7, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0);
      drain();

      set_regs(16'd100, 16'd1000, 16'd4095, 16'd5, 16'd20, 16'd110);
      add_random(330, 35);
      drain();

      set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255, 16'd1000, 16'd1000);
      send_idle_pct = 52;
      add_random(400, 35);
      drain();

      set_regs(16'd0, 16'd1, 16'd1, 16'd1, 16'd0, 16'd1);
      send_idle_pct = 0;
      stall_pct = 52;
      add_random(400, 35);
      drain();

      set_regs(16'd50, 16'd1000, 16'd4095, 16'd7, 16'd60, 16'd1023);
      send_idle_pct = 35;
      stall_pct = 35;
      @(negedge clock);
      hold_request = 1'b1;
      add_random(400, 35);
      drain();

      set_regs(16'd0, 16'd4000, 16'd60000, 16'd255, 16'hFFFF, 16'd150);
      send_idle_pct = 0;
      stall_pct = 0;
      add_item(smcn_pkg::OP_START_CAL, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0);
      for (int g = 0; g < 260; g++) begin
         add_item(smcn_pkg::OP_CAL_SAMPLE, 4'($urandom_range(0, 7)), 16'($urandom), 1'b1,
                  16'd0, 16'd0);
         if (g % 20 == 0) add_random(1, 50);
      end
      add_random(125, 35);
      drain();

      if (failed)
         $display("Mismatches found");
      else
         $display("No mismatches found");
      $finish;
   end

   initial begin
      #20000000;
      $display("Mismatches found");
      $finish;
   end
endmodule
